// File: src/rv64md_pkg.sv
package rv64md_pkg;

    localparam int XLEN = 64;
    localparam int WLEN = 32;
    localparam int TAG_W = 5;
    localparam int OP_W = 4;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_MUL    = 4'd0;
    localparam op_t OP_MULH   = 4'd1;
    localparam op_t OP_MULHSU = 4'd2;
    localparam op_t OP_MULHU  = 4'd3;
    localparam op_t OP_MULW   = 4'd4;
    localparam op_t OP_DIV    = 4'd5;
    localparam op_t OP_DIVU   = 4'd6;
    localparam op_t OP_DIVW   = 4'd7;
    localparam op_t OP_DIVUW  = 4'd8;
    localparam op_t OP_REM    = 4'd9;
    localparam op_t OP_REMU   = 4'd10;
    localparam op_t OP_REMW   = 4'd11;
    localparam op_t OP_REMUW  = 4'd12;

    typedef struct packed {
        op_t              op;
        logic [XLEN-1:0]  operand_a;
        logic [XLEN-1:0]  operand_b;
        logic [TAG_W-1:0] dest_tag;
    } in_beat_t;

    typedef struct packed {
        logic [XLEN-1:0]  result;
        logic [TAG_W-1:0] dest_tag_out;
    } out_beat_t;

    // state carried down the cell chain
    typedef struct packed {
        op_t              op;
        logic [TAG_W-1:0] tag;
        logic             is_div;
        logic [XLEN-1:0]  hi;
        logic [XLEN-1:0]  lo;
        logic [XLEN-1:0]  d;
        logic [XLEN-1:0]  corr;
        logic             neg_q;
        logic             neg_r;
    } stage_t;

    function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] v);
        return {{(XLEN-WLEN){v[WLEN-1]}}, v[WLEN-1:0]};
    endfunction

endpackage

// File: src/rv64m_multiply_divide_unit.sv
// rv64m multiply / divide execute unit
// input channel s_valid / s_ready / s_beat: one beat is one operation with its
// opcode, two 64-bit source values and a destination tag
// result channel m_valid / m_ready / m_beat: one beat per input beat, in order,
// carrying the 64-bit result and the tag unchanged
// the path is one operand preparation stage, a chain of 64 cells
// (one multiply or one divide bit per cell) and one result register
// throughput is one beat per cycle; every stage moves together, so a new beat
// is taken in each cycle the result register is empty or being taken
// when the receiver stalls with a result waiting, the whole chain holds and
// s_ready drops until m_ready returns
// reset clears all valid flags; no result is presented afterwards until a new
// beat has passed the chain
module rv64m_multiply_divide_unit
    import rv64md_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_beat,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_beat
);

    localparam int NCELLS = XLEN;

    logic   en;
    logic   chain_valid [NCELLS+1];
    stage_t chain_stage [NCELLS+1];

    // global advance: the chain moves unless a result is stuck at the output
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // sign handling, magnitudes and mulh correction
    rv64md_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_beat   (s_beat),
        .valid_reg (chain_valid[0]),
        .stage_reg (chain_stage[0])
    );

    // one bit of product or quotient per cell
    for (genvar i = 0; i < NCELLS; i++) begin : g_cell
        rv64md_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_stage  (chain_stage[i]),
            .valid_reg (chain_valid[i+1]),
            .stage_reg (chain_stage[i+1])
        );
    end

    // sign fix-up, word sign extension and result select
    rv64md_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (chain_valid[NCELLS]),
        .in_stage  (chain_stage[NCELLS]),
        .valid_reg (m_valid),
        .beat_reg  (m_beat)
    );

endmodule

// File: src/rv64md_prep.sv
module rv64md_prep
    import rv64md_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  in_beat_t in_beat,
    output logic     valid_reg,
    output stage_t   stage_reg
);

    stage_t          stage_next;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] da;
    logic [XLEN-1:0] db;
    logic            signed_div;
    logic            na;
    logic            nb;
    logic            bz;

    assign a = in_beat.operand_a;
    assign b = in_beat.operand_b;

    always_comb begin
        signed_div = 1'b0;
        da         = a;
        db         = b;
        unique case (in_beat.op)
            OP_DIV, OP_REM: begin
                signed_div = 1'b1;
            end
            OP_DIVW, OP_REMW: begin
                signed_div = 1'b1;
                da         = sext32(a);
                db         = sext32(b);
            end
            OP_DIVUW, OP_REMUW: begin
                da = {{(XLEN-WLEN){1'b0}}, a[WLEN-1:0]};
                db = {{(XLEN-WLEN){1'b0}}, b[WLEN-1:0]};
            end
            default: begin
                da = a;
                db = b;
            end
        endcase
        na = signed_div & da[XLEN-1];
        nb = signed_div & db[XLEN-1];
        bz = (db == '0);

        stage_next        = '0;
        stage_next.op     = in_beat.op;
        stage_next.tag    = in_beat.dest_tag;
        stage_next.hi     = '0;
        unique case (in_beat.op)
            OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU, OP_MULW: begin
                stage_next.is_div = 1'b0;
                stage_next.lo     = b;
                stage_next.d      = a;
            end
            default: begin
                stage_next.is_div = 1'b1;
                stage_next.lo     = na ? (~da + 1'b1) : da;
                stage_next.d      = nb ? (~db + 1'b1) : db;
            end
        endcase
        // high-half correction for signed operands
        unique case (in_beat.op)
            OP_MULH:   stage_next.corr = (a[XLEN-1] ? b : '0) + (b[XLEN-1] ? a : '0);
            OP_MULHSU: stage_next.corr = a[XLEN-1] ? b : '0;
            default:   stage_next.corr = '0;
        endcase
        // quotient keeps all ones on divide by zero
        stage_next.neg_q = (na ^ nb) & ~bz;
        stage_next.neg_r = na;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

endmodule

// File: src/rv64md_cell.sv
module rv64md_cell
    import rv64md_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  stage_t in_stage,
    output logic   valid_reg,
    output stage_t stage_reg
);

    stage_t          stage_next;
    logic [XLEN:0]   rem_ext;
    logic [XLEN+1:0] diff;
    logic [XLEN:0]   sum;

    always_comb begin
        stage_next = in_stage;
        rem_ext    = {in_stage.hi, in_stage.lo[XLEN-1]};
        diff       = {1'b0, rem_ext} - {2'b00, in_stage.d};
        sum        = {1'b0, in_stage.hi} + (in_stage.lo[0] ? {1'b0, in_stage.d} : '0);
        if (in_stage.is_div) begin
            // restoring division step
            if (!diff[XLEN+1]) begin
                stage_next.hi = diff[XLEN-1:0];
                stage_next.lo = {in_stage.lo[XLEN-2:0], 1'b1};
            end else begin
                stage_next.hi = rem_ext[XLEN-1:0];
                stage_next.lo = {in_stage.lo[XLEN-2:0], 1'b0};
            end
        end else begin
            // shift-add multiply step
            stage_next.hi = sum[XLEN:1];
            stage_next.lo = {sum[0], in_stage.lo[XLEN-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

endmodule

// File: src/rv64md_post.sv
module rv64md_post
    import rv64md_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  stage_t    in_stage,
    output logic      valid_reg,
    output out_beat_t beat_reg
);

    out_beat_t       beat_next;
    logic [XLEN-1:0] quo;
    logic [XLEN-1:0] rem;

    always_comb begin
        quo = in_stage.neg_q ? (~in_stage.lo + 1'b1) : in_stage.lo;
        rem = in_stage.neg_r ? (~in_stage.hi + 1'b1) : in_stage.hi;
        beat_next.dest_tag_out = in_stage.tag;
        unique case (in_stage.op)
            OP_MUL:                     beat_next.result = in_stage.lo;
            OP_MULH, OP_MULHSU:         beat_next.result = in_stage.hi - in_stage.corr;
            OP_MULHU:                   beat_next.result = in_stage.hi;
            OP_MULW:                    beat_next.result = sext32(in_stage.lo);
            OP_DIV, OP_DIVU:            beat_next.result = quo;
            OP_DIVW, OP_DIVUW:          beat_next.result = sext32(quo);
            OP_REM, OP_REMU:            beat_next.result = rem;
            OP_REMW, OP_REMUW:          beat_next.result = sext32(rem);
            default:                    beat_next.result = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            beat_reg <= beat_next;
        end
    end

endmodule
